// ===== rtl/frgt_pkg.sv =====
// shared types and constants for the feed record parser and gap tracker
package frgt_pkg;

   // default size of the tracked sequence space
   localparam int SEQ_SPACE_DEF = 256;

   // record layout, in byte positions
   localparam int RECORD_BYTES = 17;
   localparam int SYMBOL_BYTES = 4;
   localparam int QTY_END      = 9;
   localparam int SEQ_OFFSET   = 13;
   localparam int POS_W        = 5;
   localparam logic [POS_W-1:0] POS_SIDE = POS_W'(SYMBOL_BYTES);
   localparam logic [POS_W-1:0] POS_QTY  = POS_W'(QTY_END);
   localparam logic [POS_W-1:0] POS_SEQ  = POS_W'(SEQ_OFFSET);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(RECORD_BYTES - 1);

   // request codes
   localparam logic REQ_BYTE  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_RECORD  = 2'd0;
   localparam logic [1:0] KIND_MISSING = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   // input word
   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [1:0]         kind;
      logic [31:0]        symbol;
      logic [7:0]         side;
      logic signed [31:0] quantity;
      logic signed [31:0] price;
      logic signed [31:0] seq_number;
      logic               seq_out_of_range;
      logic               partial_record;
   } rsp_word_type;

   // controller to datapath commands
   typedef struct packed {
      logic byte_load;
      logic query_done_now;
      logic scan_start;
      logic clear_step;
      logic probe_next;
      logic emit_missing;
      logic emit_scan_done;
   } frgt_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic scan_empty;
      logic probe_end;
      logic map_bit;
      logic last_byte;
      logic out_busy;
   } frgt_status_type;

endpackage

// ===== rtl/frgt_ram.sv =====
// generic single write port ram with registered read
module frgt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/frgt_datapath.sv =====
// record assembly, seen map, scan cursor and output register
module frgt_datapath #(
   parameter int SEQ_SPACE = frgt_pkg::SEQ_SPACE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  frgt_pkg::req_word_type    req_data,
   input  frgt_pkg::frgt_cmd_type    cmd,
   output frgt_pkg::frgt_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output frgt_pkg::rsp_word_type    rsp_data
);
   import frgt_pkg::*;

   localparam int AW = $clog2(SEQ_SPACE);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      symbol_ff, symbol_in;
   logic [7:0]       side_ff, side_in;
   logic [31:0]      qty_ff, qty_in;
   logic [31:0]      price_ff, price_in;
   logic [23:0]      seqhi_ff, seqhi_in;
   logic [AW-1:0]    highest_ff, highest_in;
   logic [AW-1:0]    cursor_ff, cursor_in;
   logic [AW-1:0]    probe_ff, probe_in;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic             out_valid_ff, out_valid_in;
   rsp_word_type     out_ff, out_in;

   logic [31:0]   seq_full;
   logic          seq_oor;
   logic          emit_record;
   logic          emit_done;
   logic          partial;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic          ram_wdata;
   logic          ram_rdata;

   // sequence of the record completing on this byte
   assign seq_full    = {seqhi_ff, req_data.data_byte};
   assign seq_oor     = seq_full[31] || (seq_full >= 32'(SEQ_SPACE));
   assign emit_record = cmd.byte_load && (pos_ff == POS_LAST);
   assign emit_done   = cmd.query_done_now || cmd.emit_scan_done;
   assign partial     = (pos_ff != '0);

   // byte collection
   always_comb begin
      pos_in    = pos_ff;
      symbol_in = symbol_ff;
      side_in   = side_ff;
      qty_in    = qty_ff;
      price_in  = price_ff;
      seqhi_in  = seqhi_ff;
      if (cmd.byte_load) begin
         if (pos_ff < POS_SIDE) begin
            symbol_in = {symbol_ff[23:0], req_data.data_byte};
         end else if (pos_ff == POS_SIDE) begin
            side_in = req_data.data_byte;
         end else if (pos_ff < POS_QTY) begin
            qty_in = {qty_ff[23:0], req_data.data_byte};
         end else if (pos_ff < POS_SEQ) begin
            price_in = {price_ff[23:0], req_data.data_byte};
         end else if (pos_ff < POS_LAST) begin
            seqhi_in = {seqhi_ff[15:0], req_data.data_byte};
         end
         if (pos_ff == POS_LAST) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // seen map writes: clearing pass or a completed in-range record
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = seq_full[AW-1:0];
      ram_wdata = 1'b1;
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = 1'b0;
      end else if (emit_record && !seq_oor) begin
         ram_we = 1'b1;
      end
   end

   frgt_ram #(
      .WIDTH (1),
      .DEPTH (SEQ_SPACE)
   ) u_seen_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (probe_ff),
      .rd_data (ram_rdata)
   );

   // highest sequence, scan cursor, probe and clear counter
   always_comb begin
      highest_in = highest_ff;
      cursor_in  = cursor_ff;
      probe_in   = probe_ff;
      clr_cnt_in = clr_cnt_ff;
      if (emit_record && !seq_oor && (seq_full[AW-1:0] > highest_ff)) begin
         highest_in = seq_full[AW-1:0];
      end
      if (cmd.scan_start) begin
         probe_in = cursor_ff;
      end else if (cmd.probe_next) begin
         probe_in = probe_ff + AW'(1);
      end
      if (cmd.emit_missing) begin
         cursor_in = probe_ff + AW'(1);
      end
      if (cmd.clear_step) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
      end
   end

   // output register
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (emit_record) begin
         out_in.kind             = KIND_RECORD;
         out_in.symbol           = symbol_ff;
         out_in.side             = side_ff;
         out_in.quantity         = qty_ff;
         out_in.price            = price_ff;
         out_in.seq_number       = seq_full;
         out_in.seq_out_of_range = seq_oor;
         out_in.partial_record   = 1'b0;
         out_valid_in            = 1'b1;
      end else if (cmd.emit_missing || emit_done) begin
         out_in.kind             = cmd.emit_missing ? KIND_MISSING : KIND_DONE;
         out_in.symbol           = '0;
         out_in.side             = '0;
         out_in.quantity         = '0;
         out_in.price            = '0;
         out_in.seq_number       = cmd.emit_missing ? 32'(probe_ff) : '0;
         out_in.seq_out_of_range = 1'b0;
         out_in.partial_record   = partial;
         out_valid_in            = 1'b1;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         highest_ff   <= '0;
         cursor_ff    <= AW'(1);
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         highest_ff   <= highest_in;
         cursor_ff    <= cursor_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff <= symbol_in;
      side_ff   <= side_in;
      qty_ff    <= qty_in;
      price_ff  <= price_in;
      seqhi_ff  <= seqhi_in;
      probe_ff  <= probe_in;
      out_ff    <= out_in;
   end

   // status to the controller
   assign status.clear_last = (clr_cnt_ff == AW'(SEQ_SPACE - 1));
   assign status.scan_empty = (cursor_ff >= highest_ff);
   assign status.probe_end  = (({1'b0, probe_ff} + (AW+1)'(1)) >= {1'b0, highest_ff});
   assign status.map_bit    = ram_rdata;
   assign status.last_byte  = (pos_ff == POS_LAST);
   assign status.out_busy   = out_valid_ff && rsp_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
endmodule

// ===== rtl/frgt_ctrl.sv =====
// controller: clearing pass, input acceptance and bitmap scan sequencing
module frgt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_type,
   input  frgt_pkg::frgt_status_type status,
   output frgt_pkg::frgt_cmd_type    cmd
);
   import frgt_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR    = 4'b0001,
      ST_IDLE     = 4'b0010,
      ST_SCAN_RD  = 4'b0100,
      ST_SCAN_CHK = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      need_out;
   logic      accept;

   // stall only when busy, or when this word makes a result and the output is held
   assign need_out  = (req_type == REQ_QUERY) || status.last_byte;
   assign req_stall = (state_ff != ST_IDLE) || (need_out && status.out_busy);
   assign accept    = req_valid && !req_stall;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_BYTE) begin
                  cmd.byte_load = 1'b1;
               end else if (status.scan_empty) begin
                  cmd.query_done_now = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (!status.map_bit) begin
               cmd.emit_missing = 1'b1;
               state_in         = ST_IDLE;
            end else if (status.probe_end) begin
               cmd.emit_scan_done = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_SCAN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== rtl/feed_record_parser_gap_tracker_top.sv =====
// Feed record parser and sequence gap tracker, top level.
// Bytes are taken one per cycle unless req_stall is high; the 17th byte of a record
// puts the decoded record on rsp the next cycle. A query with nothing to scan answers
// the next cycle; otherwise it does a ram read and a check per probed seen-map entry
// and blocks input meanwhile. After reset a clearing pass zeroes the seen map, req_stall high.
module feed_record_parser_gap_tracker_top #(
   parameter int SEQ_SPACE = frgt_pkg::SEQ_SPACE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  frgt_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output frgt_pkg::rsp_word_type rsp_data
);
   import frgt_pkg::*;

   frgt_cmd_type    cmd;
   frgt_status_type status;

   // controller
   frgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_data.req_type),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   frgt_datapath #(
      .SEQ_SPACE (SEQ_SPACE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

// ===== tb/tb_top.sv =====
// testbench for the feed record parser and sequence gap tracker
module tb_top;
   import frgt_pkg::*;

   localparam int SEQ_SPACE   = SEQ_SPACE_DEF;
   localparam int ITEM_TARGET = 800;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 20;

   // tracks decoding and the seen map, holds the results still owed by the block
   class gap_scoreboard;
      rsp_word_type pending_results[$];
      int           errors;
      int           n_record, n_oor, n_missing, n_done, n_partial;
      int           pos, highest, cursor;
      logic [31:0]  sym_acc, qty_acc, price_acc;
      logic [7:0]   side_acc;
      logic [23:0]  seq_acc;
      bit           seen[SEQ_SPACE];

      function new();
         errors    = 0;
         n_record  = 0;
         n_oor     = 0;
         n_missing = 0;
         n_done    = 0;
         n_partial = 0;
         pos       = 0;
         highest   = 0;
         cursor    = 1;
         sym_acc   = '0;
         qty_acc   = '0;
         price_acc = '0;
         side_acc  = '0;
         seq_acc   = '0;
      endfunction

      // append a result to the tail of the owed list
      function void queue_result(rsp_word_type r);
         pending_results.insert(pending_results.size(), r);
      endfunction

      // work out what an accepted word makes the block emit
      function void note_request(req_word_type w);
         rsp_word_type r;
         logic [31:0]  seq;
         int           s;
         r = '0;
         if (w.req_type == REQ_QUERY) begin
            r.partial_record = (pos != 0);
            r.kind = KIND_DONE;
            s = cursor;
            while (s < highest && s < SEQ_SPACE && r.kind == KIND_DONE) begin
               if (s >= 1 && !seen[s]) begin
                  r.kind = KIND_MISSING;
                  r.seq_number = s;
                  cursor = s + 1;
               end
               s++;
            end
            if (r.kind == KIND_MISSING) n_missing++;
            else n_done++;
            if (r.partial_record) n_partial++;
            queue_result(r);
            return;
         end
         // collect the byte into its field
         if (pos < SYMBOL_BYTES) sym_acc = {sym_acc[23:0], w.data_byte};
         else if (pos == SYMBOL_BYTES) side_acc = w.data_byte;
         else if (pos < QTY_END) qty_acc = {qty_acc[23:0], w.data_byte};
         else if (pos < SEQ_OFFSET) price_acc = {price_acc[23:0], w.data_byte};
         else if (pos < RECORD_BYTES - 1) seq_acc = {seq_acc[15:0], w.data_byte};
         if (pos < RECORD_BYTES - 1) begin
            pos++;
            return;
         end
         // last byte completes the record
         seq = {seq_acc, w.data_byte};
         r.kind       = KIND_RECORD;
         r.symbol     = sym_acc;
         r.side       = side_acc;
         r.quantity   = qty_acc;
         r.price      = price_acc;
         r.seq_number = seq;
         if (!seq[31] && seq < SEQ_SPACE) begin
            seen[int'(seq)] = 1'b1;
            if (int'(seq) > highest) highest = int'(seq);
         end else begin
            r.seq_out_of_range = 1'b1;
            n_oor++;
         end
         n_record++;
         pos = 0;
         queue_result(r);
      endfunction

      function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      // compare an accepted result with the oldest one owed
      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with none owed, expected nothing, actual %h", $time, got);
            return;
         end
         want = pending_results.pop_front();
         cmp_field("kind", want.kind, got.kind);
         cmp_field("symbol", want.symbol, got.symbol);
         cmp_field("side", want.side, got.side);
         cmp_field("quantity", want.quantity, got.quantity);
         cmp_field("price", want.price, got.price);
         cmp_field("seq_number", want.seq_number, got.seq_number);
         cmp_field("seq_out_of_range", want.seq_out_of_range, got.seq_out_of_range);
         cmp_field("partial_record", want.partial_record, got.partial_record);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;

   gap_scoreboard sb;
   bit            pace_on;
   int            items_sent;

   feed_record_parser_gap_tracker_top #(
      .SEQ_SPACE(SEQ_SPACE)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // send one word, optionally after a random gap, and wait until it is taken
   task automatic send_word(input req_word_type w);
      int gap;
      gap = pace_on ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(w);
      items_sent++;
   endtask

   task automatic send_query();
      req_word_type w;
      w.req_type  = REQ_QUERY;
      w.data_byte = 8'($urandom_range(0, 255));
      send_word(w);
   endtask

   // a whole record, with a query slipped in before byte query_at if it is in range
   task automatic send_record(input logic [31:0] sym, input logic [7:0] side_b,
                              input logic [31:0] qty, input logic [31:0] price,
                              input logic [31:0] seq, input int query_at);
      logic [135:0] rec;
      req_word_type w;
      rec = {sym, side_b, qty, price, seq};
      w.req_type = REQ_BYTE;
      for (int i = 0; i < RECORD_BYTES; i++) begin
         if (i == query_at) send_query();
         w.data_byte = rec[135 - 8*i -: 8];
         send_word(w);
      end
   endtask

   // field values leaning on the extremes
   function automatic logic [31:0] pick_field();
      case ($urandom_range(0, 9))
         0: pick_field = 32'h0000_0000;
         1: pick_field = 32'hFFFF_FFFF;
         2: pick_field = 32'h8000_0000;
         3: pick_field = 32'h7FFF_FFFF;
         default: pick_field = $urandom();
      endcase
   endfunction

   // sequences mostly low so that gaps stay, with edges and out-of-range ones
   function automatic logic [31:0] pick_seq();
      case ($urandom_range(0, 19))
         0: pick_seq = 32'd0;
         1: pick_seq = 32'(SEQ_SPACE - 1);
         2: pick_seq = 32'(SEQ_SPACE);
         3: pick_seq = $urandom_range(SEQ_SPACE + 1, 32'h7FFF_FFFF);
         4: pick_seq = 32'h8000_0000 | $urandom();
         5: pick_seq = 32'h7FFF_FFFF;
         6, 7, 8: pick_seq = $urandom_range(0, SEQ_SPACE - 1);
         default: pick_seq = $urandom_range(0, 47);
      endcase
   endfunction

   // result side: random stall before each word
   initial begin : result_side
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = pace_on ? $urandom_range(0, 10) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_result(rsp_data);
      end
   end

   // watchdog on cycles with no word moving on either side
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // stimulus and end of run
   initial begin : stimulus
      int pick;
      sb         = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      pace_on    = 1'b1;
      items_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty map, extreme record with a query before its last byte, gap walk
      send_query();
      send_record(32'hFFFF_FFFF, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3,
                  RECORD_BYTES - 1);
      send_query();
      send_query();
      send_query();

      // random records, queries and junk records
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 49) == 0) pace_on = ($urandom_range(0, 2) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 70)
            send_record(pick_field(), 8'($urandom_range(0, 255)), pick_field(),
                        pick_field(), pick_seq(),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : -1);
         else if (pick < 92)
            send_query();
         else
            send_record($urandom(), 8'($urandom_range(0, 255)), $urandom(), $urandom(),
                        $urandom(), -1);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d words: %0d records (%0d out of range), %0d gaps found,",
               items_sent, sb.n_record, sb.n_oor, sb.n_missing);
      $display("%0d done answers, %0d queries with a record half received",
               sb.n_done, sb.n_partial);
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/frgt_pkg.sv
rtl/frgt_ram.sv
rtl/frgt_datapath.sv
rtl/frgt_ctrl.sv
rtl/feed_record_parser_gap_tracker_top.sv
tb/tb_top.sv
